/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for the concurrent checks of the reorder buffer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SQR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SQR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sqr_pkg.sv */
// ----------------------------------------------------------------------------
// sqr_pkg
// field widths, register codes and shared types of the reorder buffer
// ----------------------------------------------------------------------------
package sqr_pkg;

  localparam int SOURCE_W  = 4;
  localparam int SEQ_W     = 32;
  localparam int HANDLE_W  = 16;
  localparam int CLOSES_W  = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CLOSES_W-1:0] CLOSES_RESET = 5'd15;
  localparam logic [SEQ_W-1:0]    FINAL_RESET  = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL  = 2'd1;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_BEHIND = 2'd1,
    ERR_BEYOND = 2'd2
  } err_t;

  // one parked block
  typedef struct packed {
    logic                close;
    logic [HANDLE_W-1:0] handle;
  } slot_entry_t;

endpackage

/* rtl/sqr_src_table.sv */
// ----------------------------------------------------------------------------
// sqr_src_table
// per-source record memory: expected sequence, its slot position and the
// parked-slot mask; a never-written record reads as all zero
// ----------------------------------------------------------------------------
module sqr_src_table import sqr_pkg::*; #(
  parameter int SOURCES = 16,
  parameter int WINDOW  = 8
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     rd_en,
  input  logic [((SOURCES > 1) ? $clog2(SOURCES) : 1)-1:0] rd_src,
  input  logic                                     wr_en,
  input  logic [((SOURCES > 1) ? $clog2(SOURCES) : 1)-1:0] wr_src,
  input  logic [SEQ_W-1:0]                         wr_exp,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0]   wr_head,
  input  logic [WINDOW-1:0]                        wr_bits,
  output logic [SEQ_W-1:0]                         rd_exp,
  output logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0]   rd_head,
  output logic [WINDOW-1:0]                        rd_bits
);

  localparam int HW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int REC_W = SEQ_W + HW + WINDOW;

  logic [REC_W-1:0]   mem [SOURCES];
  logic [REC_W-1:0]   rdata;
  logic [SOURCES-1:0] written;
  logic               rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_src] <= {wr_exp, wr_head, wr_bits};
    end
    if (rd_en) begin
      rdata <= mem[rd_src];
    end
  end

  // per-record written flags stand in for a clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_src] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_src];
      end
    end
  end

  assign rd_exp  = rd_written ? rdata[REC_W-1 -: SEQ_W]        : '0;
  assign rd_head = rd_written ? rdata[WINDOW +: HW]            : '0;
  assign rd_bits = rd_written ? rdata[WINDOW-1:0]              : '0;

endmodule

/* rtl/sqr_slot_store.sv */
// ----------------------------------------------------------------------------
// sqr_slot_store
// parked block memory, one row of WINDOW entries per source, single port
// ----------------------------------------------------------------------------
module sqr_slot_store import sqr_pkg::*; #(
  parameter int SOURCES = 16,
  parameter int WINDOW  = 8
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic                                     rd_en,
  input  logic [((SOURCES > 1) ? $clog2(SOURCES) : 1)-1:0] src,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0]   slot,
  input  slot_entry_t                              wr_entry,
  output slot_entry_t                              rd_entry
);

  localparam int DEPTH = SOURCES * WINDOW;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] WIN_A = AW'(WINDOW);

  slot_entry_t     mem [DEPTH];
  logic [AW-1:0]   addr;

  assign addr = AW'(src) * WIN_A + AW'(slot);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= mem[addr];
    end
  end

endmodule

/* rtl/sequence_reorder_buffer.sv */
// ----------------------------------------------------------------------------
// sequence_reorder_buffer
// per-source sequence reorder buffer: in-order or final-sequence blocks are
// delivered at once and release parked successors; early blocks within the
// window are parked (dropped if the slot is taken), others are rejected
// flow: a delivered or rejected block gets its first result once the record
//   read is done; each drained parked block adds one more result
// busy: no new block is taken until the block is done (record read, then
//   one slot-memory read a cycle); an out-of-range source index is ignored
// reset: records read as zero via per-source flags, no clearing pass; the
//   slot memory is not cleared; results cannot be stalled by the receiver
`include "assert_macros.svh"

module sequence_reorder_buffer import sqr_pkg::*; #(
  parameter int SOURCES = 16,
  parameter int WINDOW  = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [SOURCE_W-1:0]  source,
  input  logic [SEQ_W-1:0]     sequence_req,
  input  logic                 is_close,
  input  logic [HANDLE_W-1:0]  block_handle,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEQ_W-1:0]     cfg_data,
  output logic                 result_valid,
  output logic [SOURCE_W-1:0]  out_source,
  output logic [HANDLE_W-1:0]  out_handle,
  output logic                 out_close,
  output logic                 all_closed,
  output logic [1:0]           error_code,
  output logic                 last
);

  localparam int SI = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int HW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [HW-1:0]    HEAD_MAX = HW'(WINDOW - 1);
  localparam logic [HW:0]      WIN_H    = (HW + 1)'(WINDOW);
  localparam logic [SEQ_W-1:0] WIN_S    = SEQ_W'(WINDOW);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_DRAIN} state_t;

  state_t              state;
  logic [SOURCE_W-1:0] src;
  logic [SEQ_W-1:0]    seq;
  logic                cls;
  logic [HANDLE_W-1:0] handle;
  logic [SEQ_W-1:0]    cur_exp;
  logic [HW-1:0]       cur_head;
  logic [WINDOW-1:0]   cur_bits;
  logic [CLOSES_W-1:0] closes_left;
  logic [SEQ_W-1:0]    final_num;

  logic [SI-1:0]       src_idx;
  logic                in_range;
  logic                accept;

  logic [SEQ_W-1:0]    t_exp;
  logic [HW-1:0]       t_head;
  logic [WINDOW-1:0]   t_bits;
  logic                tbl_wr;
  logic [SEQ_W-1:0]    tbl_exp;
  logic [HW-1:0]       tbl_head;
  logic [WINDOW-1:0]   tbl_bits;

  slot_entry_t         slot_rd_entry;
  slot_entry_t         slot_wr_entry;
  logic                slot_wr;
  logic                slot_rd;
  logic [HW-1:0]       slot_sel;

  logic [SEQ_W-1:0]    base_exp;
  logic [HW-1:0]       base_head;
  logic [WINDOW-1:0]   base_bits;
  logic                d_close;
  logic [HANDLE_W-1:0] d_handle;
  logic [SEQ_W-1:0]    exp_inc;
  logic [HW-1:0]       head_inc;
  logic                nbit;
  logic [WINDOW-1:0]   bits_clr;
  logic                match;
  logic [SEQ_W-1:0]    off;
  logic                in_win;
  logic                behind;
  logic [HW:0]         slot_sum;
  logic [HW-1:0]       park_slot;
  logic                park_free;
  logic                deliver;
  logic [CLOSES_W-1:0] cl_after;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign accept    = start && !busy;
  assign in_range  = (32'(source) < SOURCES);
  assign src_idx   = SI'(src);

  sqr_src_table #(.SOURCES(SOURCES), .WINDOW(WINDOW)) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_src  (SI'(source)),
    .wr_en   (tbl_wr),
    .wr_src  (src_idx),
    .wr_exp  (tbl_exp),
    .wr_head (tbl_head),
    .wr_bits (tbl_bits),
    .rd_exp  (t_exp),
    .rd_head (t_head),
    .rd_bits (t_bits)
  );

  sqr_slot_store #(.SOURCES(SOURCES), .WINDOW(WINDOW)) u_slots (
    .clk      (clk),
    .wr_en    (slot_wr),
    .rd_en    (slot_rd),
    .src      (src_idx),
    .slot     (slot_sel),
    .wr_entry (slot_wr_entry),
    .rd_entry (slot_rd_entry)
  );

  assign slot_wr_entry = '{close: cls, handle: handle};

  // delivered item: the incoming block on lookup, a parked one while draining
  always_comb begin
    if (state == S_DRAIN) begin
      base_exp  = cur_exp;
      base_head = cur_head;
      base_bits = cur_bits;
      d_close   = slot_rd_entry.close;
      d_handle  = slot_rd_entry.handle;
    end else begin
      base_exp  = t_exp;
      base_head = t_head;
      base_bits = t_bits;
      d_close   = cls;
      d_handle  = handle;
    end
  end

  // slot position follows expected mod WINDOW, restarting when the count wraps
  assign exp_inc  = base_exp + 1'b1;
  assign head_inc = ((base_exp == '1) || (base_head == HEAD_MAX)) ? '0 : base_head + 1'b1;
  assign nbit     = base_bits[head_inc];
  assign bits_clr = base_bits & ~(WINDOW'(1) << head_inc);

  assign match  = (seq == t_exp) || (seq == final_num);
  assign off    = seq - t_exp;
  assign in_win = (off != '0) && (off <= WIN_S);
  assign behind = (seq < t_exp);

  // a parked number past the wrap of the count is below WINDOW, its own slot
  assign slot_sum = {1'b0, t_head} + off[HW:0];
  always_comb begin
    if (behind) begin
      park_slot = seq[HW-1:0];
    end else if (slot_sum >= WIN_H) begin
      park_slot = HW'(slot_sum - WIN_H);
    end else begin
      park_slot = slot_sum[HW-1:0];
    end
  end
  assign park_free = !t_bits[park_slot];

  assign deliver  = ((state == S_LOOK) && match) || (state == S_DRAIN);
  assign cl_after = (deliver && d_close && (closes_left != '0)) ?
                    closes_left - 1'b1 : closes_left;

  always_comb begin
    tbl_wr   = 1'b0;
    tbl_exp  = exp_inc;
    tbl_head = head_inc;
    tbl_bits = base_bits;
    slot_wr  = 1'b0;
    slot_rd  = 1'b0;
    slot_sel = head_inc;
    if (deliver) begin
      if (nbit) begin
        slot_rd = 1'b1;
      end else begin
        tbl_wr = 1'b1;
      end
    end else if ((state == S_LOOK) && in_win && park_free) begin
      slot_wr  = 1'b1;
      slot_sel = park_slot;
      tbl_wr   = 1'b1;
      tbl_exp  = t_exp;
      tbl_head = t_head;
      tbl_bits = t_bits | (WINDOW'(1) << park_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src    <= source;
      seq    <= sequence_req;
      cls    <= is_close;
      handle <= block_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      closes_left  <= CLOSES_RESET;
      final_num    <= FINAL_RESET;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CLOSES: closes_left <= cfg_data[CLOSES_W-1:0];
          CFG_FINAL:  final_num   <= cfg_data;
          default: ;
        endcase
      end
      if (deliver) begin
        result_valid <= 1'b1;
        out_source   <= src;
        out_handle   <= d_handle;
        out_close    <= d_close;
        all_closed   <= (cl_after == '0);
        error_code   <= ERR_OK;
        last         <= !nbit;
        closes_left  <= cl_after;
        cur_exp      <= exp_inc;
        cur_head     <= head_inc;
        cur_bits     <= bits_clr;
      end
      case (state)
        S_IDLE: begin
          if (accept && in_range) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (match) begin
            state <= nbit ? S_DRAIN : S_IDLE;
          end else begin
            state <= S_IDLE;
            if (!in_win) begin
              result_valid <= 1'b1;
              out_source   <= src;
              out_handle   <= '0;
              out_close    <= 1'b0;
              all_closed   <= (closes_left == '0);
              error_code   <= behind ? ERR_BEHIND : ERR_BEYOND;
              last         <= 1'b1;
            end
          end
        end
        S_DRAIN: begin
          if (!nbit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SQR_ASSERT_NOW(a_slot_port, clk, rst, slot_wr, !slot_rd, "slot memory read and write collide")
  `SQR_ASSERT_NOW(a_drain_read, clk, rst, state == S_DRAIN, $past(slot_rd), "drain without read")
  `SQR_ASSERT_NEXT(a_result_src, clk, rst, state == S_IDLE, !result_valid, "result after idle")
  `SQR_ASSERT_NOW(a_closed, clk, rst, result_valid && all_closed, closes_left == '0, "closes left")

endmodule
